@@ hdl/ntc_pkg.sv @@
// Package for the number-to-text-cells block: field widths, ASCII codes and
// the digit helper functions. Depends on nothing.
`default_nettype none
package ntc_pkg;

  localparam int CELLS     = 8;
  localparam int CNT_W     = $clog2(CELLS);
  localparam int VALUE_W   = 32;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 8;
  localparam int CHAR_W    = 7;
  localparam int NIB_W     = 4;
  localparam int BITS_PER_STAGE = 8;
  localparam int NSTAGES   = VALUE_W / BITS_PER_STAGE;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h61;

  localparam logic CMD_HEX = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] bcd;
  } stage_t;

  // Eight shift-and-add-3 steps of the binary to BCD conversion. Digits only
  // carry upwards, so keeping the low eight digits gives the value modulo 10^8.
  function automatic logic [VALUE_W-1:0] dabble8(input logic [VALUE_W-1:0] bcd_in,
                                                 input logic [BITS_PER_STAGE-1:0] bits);
    logic [VALUE_W-1:0] b;
    b = bcd_in;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      for (int d = 0; d < CELLS; d++) begin
        if (b[NIB_W*d +: NIB_W] >= 4'd5) begin
          b[NIB_W*d +: NIB_W] = b[NIB_W*d +: NIB_W] + 4'd3;
        end
      end
      b = {b[VALUE_W-2:0], bits[BITS_PER_STAGE-1-s]};
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_code(input logic [NIB_W-1:0] d);
    if (d <= 4'd9) begin
      return ASCII_ZERO + CHAR_W'(d);
    end
    return ASCII_A + CHAR_W'(d - 4'd10);
  endfunction

endpackage
`default_nettype wire

@@ hdl/ntc_in_if.sv @@
// Input channel of the number-to-text-cells block: valid, ready and one
// formatting request. Depends on ntc_pkg.
`default_nettype none
interface ntc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [ntc_pkg::ROW_W-1:0]   row;
  logic [ntc_pkg::COL_W-1:0]   column;
  logic [ntc_pkg::VALUE_W-1:0] value;

  modport source (output valid, command, row, column, value, input ready);
  modport sink   (input valid, command, row, column, value, output ready);
endinterface
`default_nettype wire

@@ hdl/ntc_out_if.sv @@
// Output channel of the number-to-text-cells block: valid, ready and one
// character cell write. Depends on ntc_pkg.
`default_nettype none
interface ntc_out_if;
  logic                       valid;
  logic                       ready;
  logic [ntc_pkg::ROW_W-1:0]  cell_row;
  logic [ntc_pkg::COL_W-1:0]  cell_column;
  logic [ntc_pkg::CHAR_W-1:0] char_code;
  logic                       last;

  modport source (output valid, cell_row, cell_column, char_code, last, input ready);
  modport sink   (input valid, cell_row, cell_column, char_code, last, output ready);
endinterface
`default_nettype wire

@@ hdl/number_to_text_cells_top.sv @@
// The output channel issues one cell per cycle while cells.ready is high, and a new
// item can enter the stages while the serialiser still issues the last one's cells.
// The conversion runs through four register stages of eight BCD steps each,
// followed by a serialiser that issues the eight cells.
// Reset (synchronous, active high) clears every valid bit and the cell counter.
// Depends on ntc_pkg, ntc_in_if and ntc_out_if.
`default_nettype none
module number_to_text_cells_top (
  input  wire logic  clk,
  input  wire logic  rst,
  ntc_in_if.sink     number,
  ntc_out_if.source  cells
);
  import ntc_pkg::*;

  stage_t               st [NSTAGES];
  stage_t               st_in [NSTAGES];
  logic [NSTAGES-1:0]   st_v;
  logic [NSTAGES:0]     adv;

  logic                 ser_valid;
  logic                 ser_cmd;
  logic [ROW_W-1:0]     ser_row;
  logic [COL_W-1:0]     ser_col;
  logic [VALUE_W-1:0]   ser_digits;
  logic [CNT_W-1:0]     cnt;
  logic                 last_cell;
  logic                 ser_load;
  logic [CNT_W-1:0]     nib_idx;

  assign last_cell = (cnt == CNT_W'(CELLS - 1));

  always_comb begin
    adv[NSTAGES] = !ser_valid || (cells.ready && last_cell);
    for (int k = NSTAGES - 1; k >= 0; k--) begin
      adv[k] = !st_v[k] || adv[k+1];
    end
  end

  assign number.ready = adv[0];
  assign ser_load     = adv[NSTAGES] && st_v[NSTAGES-1];

  always_comb begin
    st_in[0].cmd   = number.command;
    st_in[0].row   = number.row;
    st_in[0].col   = number.column;
    st_in[0].value = number.value;
    st_in[0].bcd   = dabble8('0, number.value[VALUE_W-1 -: BITS_PER_STAGE]);
    for (int k = 1; k < NSTAGES; k++) begin
      st_in[k]     = st[k-1];
      st_in[k].bcd = dabble8(st[k-1].bcd,
                             st[k-1].value[VALUE_W-1-BITS_PER_STAGE*k -: BITS_PER_STAGE]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTAGES; k++) begin
      if (adv[k]) begin
        st[k] <= st_in[k];
      end
    end
    if (rst) begin
      st_v <= '0;
    end else begin
      if (adv[0]) begin
        st_v[0] <= number.valid;
      end
      for (int k = 1; k < NSTAGES; k++) begin
        if (adv[k]) begin
          st_v[k] <= st_v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_cmd    <= st[NSTAGES-1].cmd;
      ser_row    <= st[NSTAGES-1].row;
      ser_col    <= st[NSTAGES-1].col;
      ser_digits <= (st[NSTAGES-1].cmd == CMD_DEC) ? st[NSTAGES-1].bcd
                                                    : st[NSTAGES-1].value;
    end
    if (rst) begin
      ser_valid <= 1'b0;
      cnt       <= '0;
    end else if (ser_load) begin
      ser_valid <= 1'b1;
      cnt       <= '0;
    end else if (ser_valid && cells.ready) begin
      cnt <= cnt + 1'b1;
      if (last_cell) begin
        ser_valid <= 1'b0;
      end
    end
  end

  assign nib_idx = (ser_cmd == CMD_DEC) ? cnt : CNT_W'(CELLS - 1) - cnt;

  assign cells.valid       = ser_valid;
  assign cells.cell_row    = ser_row;
  assign cells.cell_column = (ser_cmd == CMD_DEC) ?
                             ser_col + COL_W'(CELLS - 1) - COL_W'(cnt) :
                             ser_col + COL_W'(cnt);
  assign cells.char_code   = digit_code(ser_digits[NIB_W*nib_idx +: NIB_W]);
  assign cells.last        = last_cell;

endmodule
`default_nettype wire

@@ hdl/ntc_checker.sv @@
// Port-level checks for number_to_text_cells_top and the bind that attaches them.
// Depends on ntc_pkg and the top level's channel ports.
`default_nettype none
module ntc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [ntc_pkg::ROW_W-1:0]  cell_row,
  input wire logic [ntc_pkg::CHAR_W-1:0] char_code,
  input wire logic                       last
);
  import ntc_pkg::*;

  logic [CNT_W-1:0] seen;
  logic [ROW_W-1:0] prev_row;
  logic             xfer;

  assign xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (xfer) begin
      prev_row <= cell_row;
    end
    if (rst) begin
      seen <= '0;
    end else if (xfer) begin
      seen <= seen + 1'b1;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before its transfer");

  a_last_every_eighth: assert property (@(posedge clk) disable iff (rst)
    xfer |-> (last == (seen == CNT_W'(CELLS - 1))))
    else $error("last not on the eighth cell of an item");

  a_row_constant: assert property (@(posedge clk) disable iff (rst)
    xfer && (seen != '0) |-> (cell_row == prev_row))
    else $error("row changed within an item");

  a_char_is_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((char_code >= 7'h30 && char_code <= 7'h39) ||
                   (char_code >= 7'h61 && char_code <= 7'h66)))
    else $error("character code is not a hex digit");

endmodule

bind number_to_text_cells_top ntc_checker u_ntc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (cells.valid),
  .out_ready (cells.ready),
  .cell_row  (cells.cell_row),
  .char_code (cells.char_code),
  .last      (cells.last)
);
`default_nettype wire
